/* rtl/core/ypd_pkg.sv */
// ----------------------------------------------------------------------------
// ypd_pkg
// shared constants, types and helper functions of the yaw/pitch direction block
// ----------------------------------------------------------------------------
package ypd_pkg;

    localparam int OUT_FRAC_BITS = 14;
    localparam int CORDIC_STAGES = 16;
    localparam int OUT_W         = OUT_FRAC_BITS + 2;

    localparam int OFS_W  = 24;
    localparam int SENS_W = 16;
    localparam int ANG_W  = 21;
    localparam int PCL_W  = 16;
    localparam int FOLD_W = 16;
    localparam int VEC_W  = 34;
    localparam int TRIG_W = 32;
    localparam int Z_W    = 25;
    localparam int PROD_W = 2 * TRIG_W;

    localparam logic [SENS_W-1:0] SENS_RESET = 16'd6554;
    localparam int PITCH_LIMIT  = 22784;
    localparam int DEG_Q8_90    = 23040;
    localparam int DEG_Q8_180   = 46080;
    localparam int DEG_Q8_360   = 92160;
    localparam int WRAP_OFFSET  = 34816;
    localparam int CORDIC_GAIN  = 652032874;

    localparam int PROD_SH = 60 - OUT_FRAC_BITS;
    localparam int SIN_SH  = 30 - OUT_FRAC_BITS;

    typedef logic signed [ANG_W-1:0]  t_ang;
    typedef logic signed [PCL_W-1:0]  t_pcl;
    typedef logic signed [FOLD_W-1:0] t_fold;
    typedef logic signed [TRIG_W-1:0] t_trig;
    typedef logic signed [OUT_W-1:0]  t_vec_out;

    typedef struct packed {
        logic neg_cos;
        t_ang yaw;
        t_ang pitch_u;
        t_pcl pitch;
    } t_side;

    function automatic logic signed [Z_W-1:0] atan_q16(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:  v = 25'sd2949120;
            1:  v = 25'sd1740967;
            2:  v = 25'sd919879;
            3:  v = 25'sd466945;
            4:  v = 25'sd234379;
            5:  v = 25'sd117304;
            6:  v = 25'sd58666;
            7:  v = 25'sd29335;
            8:  v = 25'sd14668;
            9:  v = 25'sd7334;
            10: v = 25'sd3667;
            11: v = 25'sd1833;
            12: v = 25'sd917;
            13: v = 25'sd458;
            14: v = 25'sd229;
            15: v = 25'sd115;
            16: v = 25'sd57;
            17: v = 25'sd29;
            18: v = 25'sd14;
            19: v = 25'sd7;
            20: v = 25'sd4;
            21: v = 25'sd2;
            22: v = 25'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // round q16.24 product to q16.8 and saturate to the angle range
    function automatic t_ang scale_sat(input logic signed [OFS_W+SENS_W:0] p);
        logic signed [OFS_W+SENS_W:0] t;
        t = (p + 41'sd32768) >>> 16;
        if (t > 41'sd1048575) begin
            return 21'sd1048575;
        end else if (t < -41'sd1048576) begin
            return -21'sd1048576;
        end
        return t[ANG_W-1:0];
    endfunction

    function automatic t_vec_out sat_out(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] one;
        one = PROD_W'(64'sd1 <<< OUT_FRAC_BITS);
        if (v > one) begin
            return one[OUT_W-1:0];
        end else if (v < -one) begin
            return OUT_W'(-one);
        end
        return v[OUT_W-1:0];
    endfunction

endpackage

/* rtl/core/ypd_if.sv */
// ----------------------------------------------------------------------------
// ypd channel interfaces
// request, result and configuration channels with valid/ready
// ----------------------------------------------------------------------------
interface ypd_in_if;
    logic                            valid;
    logic                            ready;
    logic signed [ypd_pkg::OFS_W-1:0] ptr_dx;
    logic signed [ypd_pkg::OFS_W-1:0] ptr_dy;
    modport source (output valid, output ptr_dx, output ptr_dy, input ready);
    modport sink   (input valid, input ptr_dx, input ptr_dy, output ready);
endinterface

interface ypd_out_if;
    logic              valid;
    logic              ready;
    ypd_pkg::t_vec_out forward_x;
    ypd_pkg::t_vec_out forward_y;
    ypd_pkg::t_vec_out forward_z;
    ypd_pkg::t_ang     yaw_degrees;
    ypd_pkg::t_pcl     pitch_clamped;
    ypd_pkg::t_ang     pitch_unclamped;
    modport source (output valid, output forward_x, output forward_y, output forward_z,
                    output yaw_degrees, output pitch_clamped, output pitch_unclamped,
                    input ready);
    modport sink   (input valid, input forward_x, input forward_y, input forward_z,
                    input yaw_degrees, input pitch_clamped, input pitch_unclamped,
                    output ready);
endinterface

interface ypd_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [ypd_pkg::SENS_W-1:0]   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/yaw_pitch_to_direction.sv */
// ----------------------------------------------------------------------------
// yaw_pitch_to_direction
// scales pointer offsets to yaw/pitch and produces the unit forward vector
// ----------------------------------------------------------------------------
// throughput one request per cycle while the output is not stalled
// pipeline stages are scale multiply, round and clamp, two modulo stages, the cordic stages, product, round
// the whole pipeline holds while the output register is full and not taken
// reset clears valid bits and loads sensitivity with 6554
module yaw_pitch_to_direction (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ypd_in_if.sink      i_in,
    ypd_cfg_if.sink     i_cfg,
    ypd_out_if.source   o_out
);
    localparam int N = ypd_pkg::CORDIC_STAGES;
    localparam int L = N + 6;
    localparam int PW = ypd_pkg::OFS_W + ypd_pkg::SENS_W + 1;

    logic                           r_v [0:L-1];
    logic [ypd_pkg::SENS_W-1:0]     r_sens;
    logic                           en;

    assign en          = !r_v[L-1] || o_out.ready;
    assign i_in.ready  = en;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens <= ypd_pkg::SENS_RESET;
        end else if (i_cfg.valid) begin
            r_sens <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < L; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (en) begin
            r_v[0] <= i_in.valid;
            for (int k = 1; k < L; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    // stage 1: scale multiply
    logic signed [PW-1:0] r1_px;
    logic signed [PW-1:0] r1_py;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_px <= PW'(i_in.ptr_dx) * $signed({1'b0, r_sens});
            r1_py <= PW'(i_in.ptr_dy) * $signed({1'b0, r_sens});
        end
    end

    // stage 2: round, saturate, clamp
    ypd_pkg::t_side r2_sd;
    ypd_pkg::t_ang  n2_pu;
    always_comb begin
        n2_pu = ypd_pkg::scale_sat(r1_py);
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_sd.neg_cos <= 1'b0;
            r2_sd.yaw     <= ypd_pkg::scale_sat(r1_px);
            r2_sd.pitch_u <= n2_pu;
            if (n2_pu > 21'sd22784) begin
                r2_sd.pitch <= 16'sd22784;
            end else if (n2_pu < -21'sd22784) begin
                r2_sd.pitch <= -16'sd22784;
            end else begin
                r2_sd.pitch <= n2_pu[ypd_pkg::PCL_W-1:0];
            end
        end
    end

    // stage 3: quotient estimate of (yaw + 2^20) >> 10 by 90
    logic [10:0]    n3_h;
    logic [21:0]    n3_qm;
    logic [10:0]    r3_h;
    logic [9:0]     r3_lo;
    logic [4:0]     r3_q;
    ypd_pkg::t_side r3_sd;
    always_comb begin
        n3_h  = {~r2_sd.yaw[20], r2_sd.yaw[19:10]};
        n3_qm = 22'(n3_h) * 22'd728;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_h  <= n3_h;
            r3_lo <= r2_sd.yaw[9:0];
            r3_q  <= n3_qm[20:16];
            r3_sd <= r2_sd;
        end
    end

    // stage 4: remainder, wrap to [-180, 180), fold to [-90, 90]
    logic [10:0]        n4_rem;
    logic [6:0]         n4_rm;
    logic [16:0]        n4_m;
    logic signed [18:0] n4_r;
    logic signed [18:0] n4_f;
    logic               n4_neg;
    ypd_pkg::t_side     r4_sd;
    ypd_pkg::t_fold     r4_yang;
    always_comb begin
        n4_rem = r3_h - 11'(r3_q) * 11'd90;
        n4_rm  = (n4_rem >= 11'd90) ? 7'(n4_rem - 11'd90) : n4_rem[6:0];
        n4_m   = {n4_rm, r3_lo};
        if (n4_m >= 17'd34816) begin
            n4_r = 19'(n4_m) - 19'sd34816;
        end else begin
            n4_r = 19'(n4_m) + 19'sd57344;
        end
        if (n4_r >= 19'sd46080) begin
            n4_r = n4_r - 19'sd92160;
        end
        n4_neg = 1'b0;
        n4_f   = n4_r;
        if (n4_r > 19'sd23040) begin
            n4_f   = 19'sd46080 - n4_r;
            n4_neg = 1'b1;
        end else if (n4_r < -19'sd23040) begin
            n4_f   = -19'sd46080 - n4_r;
            n4_neg = 1'b1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_sd.neg_cos <= n4_neg;
            r4_sd.yaw     <= r3_sd.yaw;
            r4_sd.pitch_u <= r3_sd.pitch_u;
            r4_sd.pitch   <= r3_sd.pitch;
            r4_yang       <= n4_f[ypd_pkg::FOLD_W-1:0];
        end
    end

    // cordic lanes
    ypd_pkg::t_trig cy;
    ypd_pkg::t_trig sy;
    ypd_pkg::t_trig cp;
    ypd_pkg::t_trig sp;

    ypd_cordic u_cordic_yaw (
        .i_clk (i_clk),
        .i_en  (en),
        .i_ang (r4_yang),
        .o_cos (cy),
        .o_sin (sy)
    );

    ypd_cordic u_cordic_pitch (
        .i_clk (i_clk),
        .i_en  (en),
        .i_ang (r4_sd.pitch),
        .o_cos (cp),
        .o_sin (sp)
    );

    ypd_pkg::t_side r_sd [0:N-1];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd[0] <= r4_sd;
            for (int k = 1; k < N; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    // product stage
    logic signed [ypd_pkg::PROD_W-1:0] r5_px;
    logic signed [ypd_pkg::PROD_W-1:0] r5_pz;
    ypd_pkg::t_trig                    r5_sp;
    ypd_pkg::t_side                    r5_sd;
    ypd_pkg::t_trig                    n5_cy;
    always_comb begin
        n5_cy = r_sd[N-1].neg_cos ? -cy : cy;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_px <= ypd_pkg::PROD_W'(cp) * ypd_pkg::PROD_W'(sy);
            r5_pz <= ypd_pkg::PROD_W'(cp) * ypd_pkg::PROD_W'(n5_cy);
            r5_sp <= sp;
            r5_sd <= r_sd[N-1];
        end
    end

    // round and saturate to output register
    logic signed [ypd_pkg::PROD_W-1:0] n6_fx;
    logic signed [ypd_pkg::PROD_W-1:0] n6_fz;
    logic signed [ypd_pkg::PROD_W-1:0] n6_fy;
    always_comb begin
        n6_fx = (r5_px + (64'sd1 <<< (ypd_pkg::PROD_SH - 1))) >>> ypd_pkg::PROD_SH;
        n6_fz = -((r5_pz + (64'sd1 <<< (ypd_pkg::PROD_SH - 1))) >>> ypd_pkg::PROD_SH);
        n6_fy = (ypd_pkg::PROD_W'(r5_sp) + (64'sd1 <<< (ypd_pkg::SIN_SH - 1)))
                >>> ypd_pkg::SIN_SH;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            o_out.forward_x       <= ypd_pkg::sat_out(n6_fx);
            o_out.forward_y       <= ypd_pkg::sat_out(n6_fy);
            o_out.forward_z       <= ypd_pkg::sat_out(n6_fz);
            o_out.yaw_degrees     <= r5_sd.yaw;
            o_out.pitch_clamped   <= r5_sd.pitch;
            o_out.pitch_unclamped <= r5_sd.pitch_u;
        end
    end

    assign o_out.valid = r_v[L-1];

    a_ready_follows_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready == (!o_out.valid || o_out.ready))
        else $error("input ready does not follow output stall");

    a_pitch_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.pitch_clamped <= 16'sd22784 &&
                         o_out.pitch_clamped >= -16'sd22784))
        else $error("clamped pitch outside limit");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(o_out.forward_x)))
        else $error("result changed during stall");

    a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[3] |-> (r4_yang <= 16'sd23040 && r4_yang >= -16'sd23040))
        else $error("folded yaw outside quarter range");
endmodule

/* rtl/core/ypd_cordic.sv */
// ----------------------------------------------------------------------------
// ypd_cordic
// pipelined rotation-mode cordic, one stage per iteration, angle in degrees
// ----------------------------------------------------------------------------
module ypd_cordic (
    input  logic            i_clk,
    input  logic            i_en,
    input  ypd_pkg::t_fold  i_ang,
    output ypd_pkg::t_trig  o_cos,
    output ypd_pkg::t_trig  o_sin
);
    localparam int N  = ypd_pkg::CORDIC_STAGES;
    localparam int VW = ypd_pkg::VEC_W;
    localparam int ZW = ypd_pkg::Z_W;

    logic signed [VW-1:0] r_x [0:N-1];
    logic signed [VW-1:0] r_y [0:N-1];
    logic signed [ZW-1:0] r_z [0:N-1];

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_stage
            logic signed [VW-1:0] a_x;
            logic signed [VW-1:0] a_y;
            logic signed [ZW-1:0] a_z;
            if (g == 0) begin : g_first
                assign a_x = VW'(ypd_pkg::CORDIC_GAIN);
                assign a_y = '0;
                assign a_z = ZW'(i_ang) <<< 8;
            end else begin : g_next
                assign a_x = r_x[g-1];
                assign a_y = r_y[g-1];
                assign a_z = r_z[g-1];
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (!a_z[ZW-1]) begin
                        r_x[g] <= a_x - (a_y >>> g);
                        r_y[g] <= a_y + (a_x >>> g);
                        r_z[g] <= a_z - ypd_pkg::atan_q16(g);
                    end else begin
                        r_x[g] <= a_x + (a_y >>> g);
                        r_y[g] <= a_y - (a_x >>> g);
                        r_z[g] <= a_z + ypd_pkg::atan_q16(g);
                    end
                end
            end
        end
    endgenerate

    assign o_cos = r_x[N-1][ypd_pkg::TRIG_W-1:0];
    assign o_sin = r_y[N-1][ypd_pkg::TRIG_W-1:0];
endmodule
